// File: design/assert_macros.svh
// assertion macros used by the rasterizer top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BSR_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (prop)) else $error(msg);
`define BSR_ASSERT_IMPLY(lbl, ck, rs, pre, post, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (pre) |-> (post)) else $error(msg);
`else
`define BSR_ASSERT(lbl, ck, rs, prop, msg)
`define BSR_ASSERT_IMPLY(lbl, ck, rs, pre, post, msg)
`endif
`endif

// File: design/bsr_pkg.sv
// package of the billboard sprite rasterizer: widths, defaults and item kinds
package bsr_pkg;

  localparam int TEX_SIZE_DEF   = 64;
  localparam int MAX_SCREEN_DEF = 1024;

  localparam int COORD_W = 10;
  localparam int WORD_W  = 32;
  localparam int DIM_W   = 11;
  localparam int ADDR_W  = 20;
  localparam int CFG_IDX_W = 1;

  localparam logic [DIM_W-1:0] SCREEN_W_RST = 11'd640;
  localparam logic [DIM_W-1:0] SCREEN_H_RST = 11'd480;

  typedef enum logic [1:0] {
    K_TEXEL   = 2'd0,
    K_DEPTH   = 2'd1,
    K_PROJECT = 2'd2,
    K_QUERY   = 2'd3
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCREEN_WIDTH  = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } reg_idx_t;

endpackage

// File: design/bsr_if.sv
// request and result channel interfaces of the billboard sprite rasterizer
interface bsr_item_if
  import bsr_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [1:0]               kind;
  logic [COORD_W-1:0]       coord_a;
  logic [COORD_W-1:0]       coord_b;
  logic [WORD_W-1:0]        load_value;
  logic signed [WORD_W-1:0] sprite_pos_x;
  logic signed [WORD_W-1:0] sprite_pos_y;
  logic signed [WORD_W-1:0] camera_x;
  logic signed [WORD_W-1:0] camera_y;
  logic signed [WORD_W-1:0] heading_x;
  logic signed [WORD_W-1:0] heading_y;
  logic signed [WORD_W-1:0] lens_x;
  logic signed [WORD_W-1:0] lens_y;

  modport source (
    output valid, kind, coord_a, coord_b, load_value, sprite_pos_x, sprite_pos_y,
           camera_x, camera_y, heading_x, heading_y, lens_x, lens_y,
    input  ready
  );
  modport sink (
    input  valid, kind, coord_a, coord_b, load_value, sprite_pos_x, sprite_pos_y,
           camera_x, camera_y, heading_x, heading_y, lens_x, lens_y,
    output ready
  );
endinterface

interface bsr_result_if
  import bsr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic              draw;
  logic [ADDR_W-1:0] pixel_address;
  logic [WORD_W-1:0] colour;

  modport source (output valid, draw, pixel_address, colour, input ready);
  modport sink (input valid, draw, pixel_address, colour, output ready);
endinterface

// File: design/bsr_ram.sv
// generic single write port ram with registered read
module bsr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// File: design/billboard_sprite_rasterizer.sv
// top level of the billboard sprite rasterizer: sequencer, shared multiplier and divider
//
//   channel   dir  handshake      payload
//   item      in   valid/ready    kind, coords, load value, sprite/camera vectors
//   result    out  valid/ready    draw, pixel_address, colour
//   wr_*      in   wr_en only     wr_index, wr_data (screen width, height)
//
// texel and depth loads go straight to the output register; pixel queries and projections
// use the restoring divider, one quotient bit a cycle, 31 or 33 bits.
// item ready is high only while the sequencer is idle; one item is at work at a time.
// a finished result waits in the output register while the next request is taken.
// reset is synchronous; the stores are not cleared and need no clearing pass.
`include "assert_macros.svh"

module billboard_sprite_rasterizer
  import bsr_pkg::*;
#(
  parameter int TEX_SIZE   = TEX_SIZE_DEF,
  parameter int MAX_SCREEN = MAX_SCREEN_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 wr_en,
  input  logic [CFG_IDX_W-1:0] wr_index,
  input  logic [DIM_W-1:0]     wr_data,
  bsr_item_if.sink             item,
  bsr_result_if.source         result
);

  localparam int TAW = $clog2(TEX_SIZE * TEX_SIZE);
  localparam int CAW = $clog2(MAX_SCREEN);

  typedef enum logic [13:0] {
    S_IDLE   = 14'b00000000000001,
    S_MUL    = 14'b00000000000010,
    S_ACC    = 14'b00000000000100,
    S_VIEW   = 14'b00000000001000,
    S_DIV    = 14'b00000000010000,
    S_POST   = 14'b00000000100000,
    S_CMUL   = 14'b00000001000000,
    S_CENT   = 14'b00000010000000,
    S_BOX    = 14'b00000100000000,
    S_AMUL   = 14'b00001000000000,
    S_QCHK   = 14'b00010000000000,
    S_TEXRD  = 14'b00100000000000,
    S_TEXCHK = 14'b01000000000000,
    S_DONE   = 14'b10000000000000
  } state_t;

  typedef enum logic [2:0] {
    J_VIEW  = 3'd0,
    J_RATIO = 3'd1,
    J_SIZE  = 3'd2,
    J_TX    = 3'd3,
    J_TY    = 3'd4
  } job_t;

  function automatic logic [64:0] mag65(input logic signed [64:0] v);
    return v[64] ? 65'(-v) : 65'(v);
  endfunction

  function automatic logic signed [31:0] sat_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
    logic signed [32:0] d;
    d = 33'(a) - 33'(b);
    if (d[32] != d[31]) begin
      return d[32] ? 32'sh80000000 : 32'sh7fffffff;
    end
    return d[31:0];
  endfunction

  state_t state;
  job_t   job;
  logic [2:0] step;

  logic [DIM_W-1:0] scr_w, scr_h;

  logic [COORD_W-1:0] px, py;
  logic signed [31:0] dx, dy, hx, hy, lx, ly;
  logic signed [64:0] det, nx, ny;
  logic signed [65:0] prod;

  logic signed [31:0] view_depth, ratio;
  logic signed [15:0] centre;
  logic [15:0]        size;
  logic [DIM_W-1:0]   box_left, box_right, box_top, box_bottom;

  logic [64:0] drem, dden;
  logic [32:0] dquo;
  logic [5:0]  dcnt;
  logic        dsat, dneg;

  logic [32:0]    tx_q;
  logic           ty_neg;
  logic [TAW-1:0] tex_addr;

  logic              q_draw;
  logic [ADDR_W-1:0] q_addr;
  logic [WORD_W-1:0] q_colour;

  logic              out_valid;
  logic              out_draw;
  logic [ADDR_W-1:0] out_addr;
  logic [WORD_W-1:0] out_colour;

  logic accept;
  assign accept = item.valid && item.ready;
  assign item.ready = (state == S_IDLE);

  assign result.valid         = out_valid;
  assign result.draw          = out_draw;
  assign result.pixel_address = out_addr;
  assign result.colour        = out_colour;

  // stores
  logic           tex_we, col_we;
  logic [TAW-1:0] tex_wr_addr;
  logic [31:0]    tex_rdata, col_rdata;

  assign tex_we = accept && (item.kind == K_TEXEL)
               && (33'(item.coord_a) < 33'(TEX_SIZE)) && (33'(item.coord_b) < 33'(TEX_SIZE));
  assign tex_wr_addr = TAW'(33'(item.coord_b) * 33'(TEX_SIZE) + 33'(item.coord_a));
  assign col_we = accept && (item.kind == K_DEPTH) && (33'(item.coord_a) < 33'(MAX_SCREEN));

  bsr_ram #(.WIDTH(WORD_W), .DEPTH(TEX_SIZE * TEX_SIZE)) u_tex (
    .clk     (clk),
    .wr_en   (tex_we),
    .wr_addr (tex_wr_addr),
    .wr_data (item.load_value),
    .rd_addr (tex_addr),
    .rd_data (tex_rdata)
  );

  bsr_ram #(.WIDTH(WORD_W), .DEPTH(MAX_SCREEN)) u_col (
    .clk     (clk),
    .wr_en   (col_we),
    .wr_addr (CAW'(item.coord_a)),
    .wr_data (item.load_value),
    .rd_addr (CAW'(px)),
    .rd_data (col_rdata)
  );

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] prod_next;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (state == S_CMUL) begin
      mul_a = 33'(scr_w[10:1]);
      mul_b = 33'(ratio) + 33'sd65536;
    end else if (state == S_AMUL) begin
      mul_a = 33'(py);
      mul_b = 33'(scr_w);
    end else begin
      case (step)
        3'd0: begin mul_a = 33'(lx); mul_b = 33'(hy); end
        3'd1: begin mul_a = 33'(hx); mul_b = 33'(ly); end
        3'd2: begin mul_a = 33'(hy); mul_b = 33'(dx); end
        3'd3: begin mul_a = 33'(hx); mul_b = 33'(dy); end
        3'd4: begin mul_a = 33'(lx); mul_b = 33'(dy); end
        3'd5: begin mul_a = 33'(ly); mul_b = 33'(dx); end
        default: begin mul_a = '0; mul_b = '0; end
      endcase
    end
  end

  assign prod_next = mul_a * mul_b;

  // shared restoring divider step
  logic [65:0] div_t;
  logic        div_ge;
  logic [65:0] div_diff;
  logic [64:0] rem_next;
  logic [30:0] res31;
  logic signed [31:0] sres;

  assign div_t    = {drem, dquo[32]};
  assign div_ge   = div_t >= {1'b0, dden};
  assign div_diff = div_t - {1'b0, dden};
  assign rem_next = div_ge ? div_diff[64:0] : div_t[64:0];
  assign res31    = dsat ? 31'h7fffffff : dquo[30:0];
  assign sres     = dneg ? -$signed({1'b0, res31}) : $signed({1'b0, res31});

  // q16 division operands by the state that starts it
  logic [64:0] q_ua, q_ub;
  logic        q_sat;

  always_comb begin
    if (state == S_VIEW) begin
      q_ua = mag65(ny);
      q_ub = mag65(det);
    end else if (state == S_POST) begin
      q_ua = mag65(nx);
      q_ub = mag65(ny);
    end else begin
      q_ua = 65'(scr_h);
      q_ub = 65'($unsigned(view_depth));
    end
  end

  assign q_sat = {15'b0, q_ua[64:15]} >= q_ub;

  // centre column from the registered product, truncated toward zero
  logic signed [65:0] c_val;
  logic signed [15:0] c_clamp;

  assign c_val = prod[65] ? ((prod + 66'sd65535) >>> 16) : (prod >>> 16);

  always_comb begin
    if (c_val > 66'sd32767) begin
      c_clamp = 16'sh7fff;
    end else if (c_val < -66'sd32768) begin
      c_clamp = 16'sh8000;
    end else begin
      c_clamp = c_val[15:0];
    end
  end

  // draw box
  logic signed [19:0] bx_hh, bx_sz2, bx_cen, bx_w, bx_h;
  logic signed [19:0] bx_top, bx_bot, bx_left, bx_right;
  logic [DIM_W-1:0]   b_top, b_bot, b_left, b_right;

  assign bx_hh  = 20'(scr_h[10:1]);
  assign bx_sz2 = 20'(size[15:1]);
  assign bx_cen = 20'(centre);
  assign bx_w   = 20'(scr_w);
  assign bx_h   = 20'(scr_h);
  assign bx_top   = bx_hh - bx_sz2;
  assign bx_bot   = bx_hh + bx_sz2;
  assign bx_left  = bx_cen - bx_sz2;
  assign bx_right = bx_cen + bx_sz2;

  always_comb begin
    logic signed [19:0] t;
    b_top = (bx_top < 0) ? '0 : bx_top[10:0];
    t = (bx_bot >= bx_h) ? bx_h - 20'sd1 : bx_bot;
    b_bot = (t < 0) ? '0 : t[10:0];
    if (bx_left < 0) begin
      b_left = '0;
    end else if (bx_left > bx_w) begin
      b_left = scr_w;
    end else begin
      b_left = bx_left[10:0];
    end
    t = (bx_right >= bx_w) ? bx_w - 20'sd1 : bx_right;
    b_right = (t < 0) ? '0 : t[10:0];
  end

  // query arithmetic
  logic signed [17:0] q_start;
  logic signed [18:0] q_xs;
  logic [18:0]        q_xs_u;
  logic [32:0]        tx_num, ty_num;
  logic signed [25:0] i_val;
  logic [25:0]        i_mag;
  logic               q_ok;
  logic [24:0]        ty_mag;
  logic [24:0]        ty_val;
  logic               tex_ok;

  assign q_start = 18'(centre) - 18'(size[15:1]);
  assign q_xs    = 19'(px) - 19'(q_start);
  assign q_xs_u  = q_xs;
  assign tx_num  = 33'(q_xs_u) * 33'(TEX_SIZE);
  assign i_val   = (26'(py) << 8) - (26'(scr_h) << 7) + (26'(size) << 7);
  assign i_mag   = i_val[25] ? 26'(-i_val) : 26'(i_val);
  assign ty_num  = 33'(i_mag) * 33'(TEX_SIZE);

  assign q_ok = (view_depth > 0) && (size != '0)
             && ({1'b0, px} >= box_left) && ({1'b0, px} < box_right)
             && ({1'b0, py} >= box_top) && ({1'b0, py} < box_bottom)
             && ({1'b0, px} < scr_w) && (33'(px) < 33'(MAX_SCREEN))
             && ($unsigned(view_depth) < col_rdata);

  assign ty_mag = dquo[32:8];
  assign ty_val = ty_neg ? '0 : ty_mag;
  assign tex_ok = (tx_q < 33'(TEX_SIZE))
               && (ty_neg ? (ty_mag == '0) : (33'(ty_mag) < 33'(TEX_SIZE)));

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      job        <= J_VIEW;
      step       <= '0;
      out_valid  <= 1'b0;
      scr_w      <= SCREEN_W_RST;
      scr_h      <= SCREEN_H_RST;
      view_depth <= '0;
      centre     <= '0;
      size       <= '0;
      box_left   <= '0;
      box_right  <= '0;
      box_top    <= '0;
      box_bottom <= '0;
    end else begin
      if (wr_en) begin
        unique case (wr_index)
          REG_SCREEN_WIDTH:  scr_w <= wr_data;
          REG_SCREEN_HEIGHT: scr_h <= wr_data;
          default: ;
        endcase
      end

      // s_done reloads the output register on its own
      if (result.valid && result.ready && state != S_DONE) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            px       <= item.coord_a;
            py       <= item.coord_b;
            dx       <= sat_sub(item.sprite_pos_x, item.camera_x);
            dy       <= sat_sub(item.sprite_pos_y, item.camera_y);
            hx       <= item.heading_x;
            hy       <= item.heading_y;
            lx       <= item.lens_x;
            ly       <= item.lens_y;
            step     <= '0;
            q_draw   <= 1'b0;
            q_addr   <= '0;
            q_colour <= '0;
            unique case (item.kind)
              K_TEXEL, K_DEPTH: state <= S_DONE;
              K_PROJECT:        state <= S_MUL;
              K_QUERY:          state <= S_AMUL;
              default:          state <= S_DONE;
            endcase
          end
        end

        S_MUL: begin
          prod  <= prod_next;
          state <= S_ACC;
        end

        S_ACC: begin
          case (step)
            3'd0: det <= prod[64:0];
            3'd1: det <= det - prod[64:0];
            3'd2: nx  <= prod[64:0];
            3'd3: nx  <= nx - prod[64:0];
            3'd4: ny  <= prod[64:0];
            3'd5: ny  <= ny - prod[64:0];
            default: ;
          endcase
          step  <= step + 3'd1;
          state <= (step == 3'd5) ? S_VIEW : S_MUL;
        end

        S_VIEW: begin
          if (det == '0) begin
            view_depth <= '0;
            centre     <= '0;
            size       <= '0;
            box_left   <= '0;
            box_right  <= '0;
            box_top    <= '0;
            box_bottom <= '0;
            state      <= S_DONE;
          end else begin
            drem  <= {15'b0, q_ua[64:15]};
            dquo  <= {q_ua[14:0], 18'b0};
            dden  <= q_ub;
            dcnt  <= 6'd31;
            dsat  <= q_sat;
            dneg  <= ny[64] ^ det[64];
            job   <= J_VIEW;
            state <= S_DIV;
          end
        end

        S_DIV: begin
          if (dsat || dcnt == '0) begin
            state <= S_POST;
          end else begin
            drem <= rem_next;
            dquo <= {dquo[31:0], div_ge};
            dcnt <= dcnt - 6'd1;
          end
        end

        S_POST: begin
          unique case (job)
            J_VIEW: begin
              view_depth <= sres;
              if (sres <= 0) begin
                centre     <= '0;
                size       <= '0;
                box_left   <= '0;
                box_right  <= '0;
                box_top    <= '0;
                box_bottom <= '0;
                state      <= S_DONE;
              end else begin
                drem  <= {15'b0, q_ua[64:15]};
                dquo  <= {q_ua[14:0], 18'b0};
                dden  <= q_ub;
                dcnt  <= 6'd31;
                dsat  <= q_sat;
                dneg  <= nx[64] ^ ny[64];
                job   <= J_RATIO;
                state <= S_DIV;
              end
            end
            J_RATIO: begin
              ratio <= sres;
              state <= S_CMUL;
            end
            J_SIZE: begin
              size  <= (res31 > 31'd65535) ? 16'hffff : res31[15:0];
              state <= S_BOX;
            end
            J_TX: begin
              tx_q   <= dquo;
              ty_neg <= i_val[25];
              drem   <= '0;
              dquo   <= ty_num;
              dden   <= 65'(size);
              dcnt   <= 6'd33;
              dsat   <= 1'b0;
              job    <= J_TY;
              state  <= S_DIV;
            end
            J_TY: begin
              tex_addr <= TAW'(33'(ty_val) * 33'(TEX_SIZE) + tx_q);
              state    <= tex_ok ? S_TEXRD : S_DONE;
            end
            default: state <= S_DONE;
          endcase
        end

        S_CMUL: begin
          prod  <= prod_next;
          state <= S_CENT;
        end

        S_CENT: begin
          centre <= c_clamp;
          drem   <= {15'b0, q_ua[64:15]};
          dquo   <= {q_ua[14:0], 18'b0};
          dden   <= q_ub;
          dcnt   <= 6'd31;
          dsat   <= q_sat;
          dneg   <= 1'b0;
          job    <= J_SIZE;
          state  <= S_DIV;
        end

        S_BOX: begin
          box_top    <= b_top;
          box_bottom <= b_bot;
          box_left   <= b_left;
          box_right  <= b_right;
          state      <= S_DONE;
        end

        S_AMUL: begin
          prod  <= prod_next;
          state <= S_QCHK;
        end

        S_QCHK: begin
          q_addr <= prod[19:0] + 20'(px);
          if (q_ok) begin
            drem  <= '0;
            dquo  <= tx_num;
            dden  <= 65'(size);
            dcnt  <= 6'd33;
            dsat  <= 1'b0;
            job   <= J_TX;
            state <= S_DIV;
          end else begin
            state <= S_DONE;
          end
        end

        S_TEXRD: begin
          state <= S_TEXCHK;
        end

        S_TEXCHK: begin
          q_draw   <= (tex_rdata[23:0] != '0);
          q_colour <= (tex_rdata[23:0] != '0) ? tex_rdata : '0;
          state    <= S_DONE;
        end

        S_DONE: begin
          if (!out_valid || result.ready) begin
            out_valid  <= 1'b1;
            out_draw   <= q_draw;
            out_addr   <= q_addr;
            out_colour <= q_colour;
            state      <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

  `BSR_ASSERT_IMPLY(a_busy_after_req, clk, rst, item.valid && item.ready, ##1 (state != S_IDLE), "sequencer idle right after a request")
  `BSR_ASSERT_IMPLY(a_div_rem_below, clk, rst, (state == S_DIV) && !dsat, drem < dden, "divider remainder not below divisor")
  `BSR_ASSERT(a_draw_colour, clk, rst, (result.valid && result.draw) |-> (result.colour[23:0] != '0), "draw with blank texel")
  `BSR_ASSERT(a_nodraw_zero, clk, rst, (result.valid && !result.draw) |-> (result.colour == '0), "colour given without draw")

endmodule
